// ----- sv/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register codes and helpers of the masked byte pattern
// search block.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // longest pattern the window can hold
  localparam int unsigned PATTERN_MAX = 16;

  // field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned REG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned REG_BYTES   = REG_W / BYTE_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH     = 8'd0,
    REG_PATTERN_VALUE_LOW  = 8'd1,
    REG_PATTERN_VALUE_HIGH = 8'd2,
    REG_PATTERN_MASK_LOW   = 8'd3,
    REG_PATTERN_MASK_HIGH  = 8'd4
  } cfg_reg_e;

  // compare byte handed to one window cell
  typedef struct packed {
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] value;
  } cell_pat_t;

  // pick pattern byte idx out of a low/high register pair, zero beyond them
  function automatic logic [BYTE_W-1:0] reg_byte(
    input logic [REG_W-1:0] lo,
    input logic [REG_W-1:0] hi,
    input logic [LEN_W-1:0] idx
  );
    logic [BYTE_W-1:0] b;
    b = '0;
    if (32'(idx) < REG_BYTES) begin
      b = lo[{idx[2:0], 3'b000} +: BYTE_W];
    end else if (32'(idx) < 2 * REG_BYTES) begin
      b = hi[{idx[2:0], 3'b000} +: BYTE_W];
    end
    return b;
  endfunction

endpackage

// ----- sv/mbps_cell.sv -----
// ----------------------------------------------------------------------------
// mbps_cell
// One window cell: holds one buffer byte, passes it to the next older cell
// on every accepted item and flags whether it fits its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  cell_pat_t         pat_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] byte_q, byte_d;

  // take the neighbor's byte when an item moves the window
  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // masked compare, a zero mask with zero value is a wildcard
  assign hit_o  = (byte_q & pat_i.mask) == pat_i.value;
  assign byte_o = byte_q;

endmodule

// ----- sv/masked_byte_pattern_search.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Scans a byte stream for a masked pattern of up to 16 bytes and reports the
// offset of the first match of each buffer, or not-found on its last byte.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tdata[7:0] data_byte, tlast last_byte
//  m_axis    out        tdata[31:0] match_offset, tuser found
//  cfg       in         cfg_index_i register index, cfg_data_i write data
//
//  One item per cycle is accepted while the output side does not stall; the
//  window cells shift in the accept cycle, the cells compare and the match
//  is decided in the next cycle, and the result is then registered.
//  A stalled output holds one item in the compare stage before the input
//  side stalls. Reset clears the window, counters and the output valid.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // last_byte
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [31:0] match_offset
  output logic                 m_axis_tuser,   // [0] found
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [LEN_W-1:0] len_q;
  logic [REG_W-1:0] val_lo_q, val_hi_q, mask_lo_q, mask_hi_q;

  // control and stage registers
  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [POS_W-1:0] s1_pos_q, s1_pos_d;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_last_q, s1_last_d;
  logic             reported_q, reported_d;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [POS_W-1:0] out_offset_q, out_offset_d;

  logic             in_accept, out_free, s1_adv;
  logic             len_ok, pos_ok, all_hit, match, res_valid;

  logic [BYTE_W-1:0] win_byte [PATTERN_MAX];
  cell_pat_t         cell_pat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit;

  assign cfg_ready_o = 1'b1;

  // configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      val_lo_q  <= '0;
      val_hi_q  <= '0;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_LENGTH:     len_q     <= cfg_data_i[LEN_W-1:0];
        REG_PATTERN_VALUE_LOW:  val_lo_q  <= cfg_data_i;
        REG_PATTERN_VALUE_HIGH: val_hi_q  <= cfg_data_i;
        REG_PATTERN_MASK_LOW:   mask_lo_q <= cfg_data_i;
        REG_PATTERN_MASK_HIGH:  mask_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // align pattern bytes to cells: cell k (k bytes old) meets byte len-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_align
    logic [LEN_W-1:0] idx;
    always_comb begin
      idx = LEN_W'(32'(len_q) - 32'(k) - 32'd1);
      cell_pat[k] = '0;
      if (32'(k) < 32'(len_q)) begin
        cell_pat[k].mask  = reg_byte(mask_lo_q, mask_hi_q, idx);
        cell_pat[k].value = reg_byte(val_lo_q, val_hi_q, idx);
      end
    end
  end

  // window cell chain, cell 0 takes the newest byte
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    if (k == 0) begin : g_head
      assign byte_in = s_axis_tdata;
    end else begin : g_link
      assign byte_in = win_byte[k-1];
    end
    mbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_accept),
      .byte_i  (byte_in),
      .pat_i   (cell_pat[k]),
      .byte_o  (win_byte[k]),
      .hit_o   (hit[k])
    );
  end

  // saturating byte count of the current buffer
  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

  always_comb begin
    pos_d      = pos_q;
    s1_pos_d   = s1_pos_q;
    s1_last_d  = s1_last_q;
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_accept) begin
      pos_d      = s_axis_tlast ? '0 : pos_inc;
      s1_pos_d   = pos_inc;
      s1_last_d  = s_axis_tlast;
      s1_valid_d = 1'b1;
    end
  end

  // match decision of the item in the compare stage
  assign len_ok    = (len_q != '0) && (32'(len_q) <= PATTERN_MAX);
  assign pos_ok    = s1_pos_q >= POS_W'(len_q);
  assign all_hit   = &hit;
  assign match     = len_ok && pos_ok && all_hit;
  assign res_valid = s1_valid_q && !reported_q && (match || s1_last_q);

  // result register and first-match flag
  always_comb begin
    reported_d   = reported_q;
    out_found_d  = out_found_q;
    out_offset_d = out_offset_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    if (s1_adv) begin
      if (res_valid) begin
        out_valid_d  = 1'b1;
        out_found_d  = match;
        out_offset_d = match ? s1_pos_q - POS_W'(len_q) : '0;
      end
      if (s1_last_q) begin
        reported_d = 1'b0;
      end else if (match) begin
        reported_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      s1_valid_q  <= s1_valid_d;
      s1_last_q   <= s1_last_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_pos_q     <= s1_pos_d;
    out_found_q  <= out_found_d;
    out_offset_q <= out_offset_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_offset_q;
  assign m_axis_tuser  = out_found_q;

endmodule

// ----- sv/mbps_checker.sv -----
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte pattern search block, bound to the
// top level.
// ----------------------------------------------------------------------------
module mbps_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [31:0]          m_axis_tdata,
  input logic                 m_axis_tuser
);

  // a stalled result keeps its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a not-found result carries a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found result with nonzero offset");

  // a fresh result follows an accepted item through the compare stage and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input item");

  // a fresh not-found result comes only from a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && !m_axis_tuser |-> $past(s_axis_tlast, 2))
    else $error("not-found result before the end of the buffer");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);

// ----- tb/sv/masked_byte_pattern_search_check.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_check
// Watches the input, result and configuration channels of the pattern search
// block, keeps its own window and pattern registers, predicts the result of
// every buffer and compares each result item field by field.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_check
  import mbps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream as seen at the block
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // last_byte
  // result stream as seen at the block
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [31:0]          m_axis_tdata,   // [31:0] match_offset
  input  logic                 m_axis_tuser,   // [0] found
  // configuration writes
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  // status for the test top
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          found_count_o,
  output int unsigned          miss_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            found;
    logic [POS_W-1:0] offset;
  } scan_result_t;

  // results still owed by the block, oldest first
  scan_result_t      owed_results[$];

  // search state, index 0 of the window holds the newest byte
  logic [BYTE_W-1:0] window [PATTERN_MAX];
  logic [POS_W-1:0]  bytes_seen;
  logic              match_reported;

  // pattern registers as written through the configuration channel
  logic [LEN_W-1:0]   pat_len;
  logic [2*REG_W-1:0] pat_value;
  logic [2*REG_W-1:0] pat_mask;

  int unsigned fails;
  int unsigned found_n;
  int unsigned miss_n;

  // masked compare of the window against the first pat_len pattern bytes
  function automatic logic window_hits();
    int unsigned       n;
    int unsigned       k;
    logic [BYTE_W-1:0] b;
    logic              hit;
    n   = pat_len;
    hit = 1'b1;
    for (k = 0; k < n; k++) begin
      b = window[n - 1 - k];
      if ((b & pat_mask[8*k +: 8]) != pat_value[8*k +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  // advance the search by one accepted byte and note any result it causes
  task automatic scan_byte(input logic [7:0] b, input logic last);
    scan_result_t r;
    int           k;
    for (k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (bytes_seen != '1) bytes_seen++;
    if (!match_reported) begin
      if (pat_len != 0 && pat_len <= PATTERN_MAX && bytes_seen >= pat_len &&
          window_hits()) begin
        r.found        = 1'b1;
        r.offset       = bytes_seen - pat_len;
        match_reported = 1'b1;
        owed_results.push_back(r);
      end else if (last) begin
        r = '0;
        owed_results.push_back(r);
      end
    end
    // a new buffer starts after the last byte
    if (last) begin
      foreach (window[k]) window[k] = '0;
      bytes_seen     = '0;
      match_reported = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result(input logic found, input logic [31:0] offset);
    scan_result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("result item with none owed", offset, 32'd0);
    end else begin
      want = owed_results.pop_front();
      if (want.found) found_n++;
      else miss_n++;
      if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
      if (offset !== want.offset) report_mismatch("match_offset", offset, want.offset);
    end
  endtask

  // all three channels are sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_results.delete();
      foreach (window[k]) window[k] = '0;
      bytes_seen     = '0;
      match_reported = 1'b0;
      pat_len        = '0;
      pat_value      = '0;
      pat_mask       = '0;
      fails          = 0;
      found_n        = 0;
      miss_n         = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      found_count_o <= 0;
      miss_count_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tuser, m_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PATTERN_LENGTH:     pat_len                     = cfg_data_i[LEN_W-1:0];
          REG_PATTERN_VALUE_LOW:  pat_value[REG_W-1:0]        = cfg_data_i;
          REG_PATTERN_VALUE_HIGH: pat_value[2*REG_W-1:REG_W]  = cfg_data_i;
          REG_PATTERN_MASK_LOW:   pat_mask[REG_W-1:0]         = cfg_data_i;
          REG_PATTERN_MASK_HIGH:  pat_mask[2*REG_W-1:REG_W]   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
      fail_count_o  <= fails;
      pending_o     <= owed_results.size();
      found_count_o <= found_n;
      miss_count_o  <= miss_n;
    end
  end

endmodule

// ----- tb/sv/masked_byte_pattern_search_test.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_test
// Drives buffers of bytes through the pattern search block under a series of
// pattern settings, with bursty input and a stalling result side, and leaves
// prediction and comparison to the channel checker.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_test;
  import mbps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // kinds of pattern setting visited by the random part
  typedef enum int unsigned {
    SET_ZERO_LEN,
    SET_ONE_BYTE,
    SET_FULL_EXACT,
    SET_OVERSIZE,
    SET_ALL_WILDCARD,
    SET_MIXED,
    SET_ALL_ONES
  } set_kind_e;

  // stall behaviors of the result side
  typedef enum int unsigned {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_BYTES = 22;
  localparam int unsigned HOLD_PHASE  = 4;
  localparam int unsigned HOLD_CYCLES = 80;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [REG_W-1:0]     cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned found_count;
  int unsigned miss_count;

  // pattern currently programmed, used to plant matches
  logic [LEN_W-1:0]   cur_len = '0;
  logic [2*REG_W-1:0] cur_val = '0;
  logic [2*REG_W-1:0] cur_msk = '0;

  int unsigned burst_left    = 0;
  bit          gapless       = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned bytes_sent    = 0;
  int unsigned buffers_sent  = 0;
  int unsigned settings_used = 0;

  always #5 clk_i = ~clk_i;

  masked_byte_pattern_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  masked_byte_pattern_search_check checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .found_count_o (found_count),
    .miss_count_o  (miss_count)
  );

  // result side: changing stall modes plus one long hold-off on request
  rx_mode_e    rx_mode     = RX_STEADY;
  int unsigned rx_left     = 0;
  int unsigned hold_cycles = 0;
  bit          hold_done   = 1'b0;

  always @(posedge clk_i) begin
    if (long_hold_req && !hold_done) begin
      hold_done   = 1'b1;
      hold_cycles = HOLD_CYCLES;
    end
    if (hold_cycles != 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 40);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("masked_byte_pattern_search test failed");
    $finish;
  end

  // one byte item, opening a new burst after a random gap when due
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gapless) gap = 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    bytes_sent++;
    if (last) buffers_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and let every owed result and the pipeline drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [REG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // length register gets random bits above the five that count
  task automatic program_pattern();
    logic [REG_W-1:0] len_word;
    len_word        = {$urandom, $urandom};
    len_word[4:0]   = cur_len;
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_PATTERN_VALUE_LOW, cur_val[REG_W-1:0]);
    write_reg(REG_PATTERN_VALUE_HIGH, cur_val[2*REG_W-1:REG_W]);
    write_reg(REG_PATTERN_MASK_LOW, cur_msk[REG_W-1:0]);
    write_reg(REG_PATTERN_MASK_HIGH, cur_msk[2*REG_W-1:REG_W]);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // bytes beyond the length stay random to show they are ignored
  task automatic choose_pattern(input set_kind_e kind);
    int unsigned       k;
    logic [BYTE_W-1:0] m;
    cur_val = {$urandom, $urandom, $urandom, $urandom};
    cur_msk = {$urandom, $urandom, $urandom, $urandom};
    case (kind)
      SET_ZERO_LEN: cur_len = '0;
      SET_ONE_BYTE: begin
        cur_len      = 5'd1;
        cur_msk[7:0] = 8'hff;
      end
      SET_FULL_EXACT: begin
        cur_len = 5'(PATTERN_MAX);
        cur_msk = '1;
      end
      SET_OVERSIZE: begin
        cur_len = 5'($urandom_range(PATTERN_MAX + 1, 31));
        cur_val = cur_val & cur_msk;
      end
      SET_ALL_WILDCARD: begin
        cur_len = 5'($urandom_range(1, PATTERN_MAX));
        for (k = 0; k < cur_len; k++) begin
          cur_msk[8*k +: 8] = '0;
          cur_val[8*k +: 8] = '0;
        end
      end
      SET_MIXED: begin
        cur_len = 5'($urandom_range(1, PATTERN_MAX));
        for (k = 0; k < cur_len; k++) begin
          case ($urandom_range(0, 2))
            0:       m = 8'hff;
            1:       m = 8'h00;
            default: m = 8'($urandom);
          endcase
          cur_msk[8*k +: 8] = m;
          cur_val[8*k +: 8] = cur_val[8*k +: 8] & m;
        end
        // now and then a byte that wants bits its mask drops
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(0, cur_len - 1);
          cur_msk[8*k +: 8] = 8'h0f;
          cur_val[8*k +: 8] = 8'hf0 | (cur_val[8*k +: 8] & 8'h0f);
        end
      end
      default: begin
        cur_len = 5'(PATTERN_MAX);
        cur_msk = '1;
        cur_val = '1;
      end
    endcase
  endtask

  // random buffer, often carrying the pattern, sometimes one bit off
  task automatic send_random_buffer();
    int unsigned       plen;
    int unsigned       blen;
    int unsigned       at;
    int unsigned       bad;
    int unsigned       i;
    int unsigned       k;
    bit                plant;
    bit                spoil;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] m;
    plen  = (cur_len > PATTERN_MAX) ? PATTERN_MAX : cur_len;
    blen  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48)
                                        : $urandom_range(1, plen + 6);
    plant = plen != 0 && blen >= plen && $urandom_range(0, 2) != 0;
    at    = plant ? $urandom_range(0, blen - plen) : 0;
    spoil = plant && $urandom_range(0, 3) == 0;
    bad   = plant ? $urandom_range(0, plen - 1) : 0;
    for (i = 0; i < blen; i++) begin
      b = 8'($urandom);
      if (plant && i >= at && i < at + plen) begin
        k = i - at;
        m = cur_msk[8*k +: 8];
        b = cur_val[8*k +: 8] | (b & ~m);
        if (spoil && k == bad) b = b ^ (m & (~m + 8'd1));
      end
      send_byte(b, i == blen - 1);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned start_bytes;
    set_kind_e   kind;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length straight out of reset: not-found on the last byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_idle();

    // exact four byte pattern
    cur_len = 5'd4;
    cur_val = 128'h44332211;
    cur_msk = 128'hffffffff;
    program_pattern();
    // buffer shorter than the pattern
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    // match ending on the last byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    // match at offset zero, later bytes and the last one stay silent
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h11, 1'b1);
    // one byte buffer
    send_byte(8'h11, 1'b1);
    wait_idle();

    // a value bit outside its mask can never match
    cur_len = 5'd2;
    cur_val = 128'h001f;
    cur_msk = 128'hff0f;
    program_pattern();
    send_byte(8'h1f, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();

    // length above the window never matches, even with all wildcards
    cur_len = 5'd17;
    cur_val = '0;
    cur_msk = '0;
    program_pattern();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();

    // random part, each kind once and then random kinds
    for (phase = 0; phase < PHASES; phase++) begin
      kind = (phase < 7) ? set_kind_e'(phase) : set_kind_e'($urandom_range(0, 6));
      choose_pattern(kind);
      // one byte wildcard matches every buffer: back-pressure fills the block
      if (phase == HOLD_PHASE) begin
        cur_len = 5'd1;
        gapless = 1'b1;
        long_hold_req <= 1'b1;
      end
      program_pattern();
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) send_random_buffer();
      gapless = 1'b0;
      wait_idle();
    end

    $display("sent %0d bytes in %0d buffers under %0d pattern settings",
             bytes_sent, buffers_sent, settings_used);
    $display("compared %0d match offsets and %0d not-found results",
             found_count, miss_count);
    if (fail_count == 0 && pending == 0) begin
      $display("masked_byte_pattern_search test passed");
    end else begin
      $display("masked_byte_pattern_search test failed");
    end
    $finish;
  end

endmodule
